// File: rtl/smeu_pkg.sv
// Shared types and constants for the stack machine execute unit.
// No dependencies; every other file of the unit imports this package.
`default_nettype none

package smeu_pkg;

  localparam int DATA_W          = 16;
  localparam int ARG_W           = 32;
  localparam int CMD_W           = 5;
  localparam int KIND_W          = 2;
  localparam int MEMOP_W         = 2;
  localparam int DEPTH_OUT_W     = 5;
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [CMD_W-1:0] OP_MOV = 5'd0;
  localparam logic [CMD_W-1:0] OP_PSH = 5'd1;
  localparam logic [CMD_W-1:0] OP_POP = 5'd2;
  localparam logic [CMD_W-1:0] OP_SWP = 5'd3;
  localparam logic [CMD_W-1:0] OP_REM = 5'd4;
  localparam logic [CMD_W-1:0] OP_ADD = 5'd5;
  localparam logic [CMD_W-1:0] OP_SUB = 5'd6;
  localparam logic [CMD_W-1:0] OP_MUL = 5'd7;
  localparam logic [CMD_W-1:0] OP_DIV = 5'd8;
  localparam logic [CMD_W-1:0] OP_NEG = 5'd9;
  localparam logic [CMD_W-1:0] OP_AND = 5'd10;
  localparam logic [CMD_W-1:0] OP_NOR = 5'd11;
  localparam logic [CMD_W-1:0] OP_IFZ = 5'd12;
  localparam logic [CMD_W-1:0] OP_IFN = 5'd13;
  localparam logic [CMD_W-1:0] OP_IFG = 5'd14;
  localparam logic [CMD_W-1:0] OP_IFL = 5'd15;
  localparam logic [CMD_W-1:0] OP_JMP = 5'd16;
  localparam logic [CMD_W-1:0] OP_JSR = 5'd17;
  localparam logic [CMD_W-1:0] OP_RET = 5'd18;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADDR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IMM  = 2'd2;

  localparam logic [MEMOP_W-1:0] MEM_NONE  = 2'd0;
  localparam logic [MEMOP_W-1:0] MEM_SET   = 2'd1;
  localparam logic [MEMOP_W-1:0] MEM_MOVE  = 2'd2;
  localparam logic [MEMOP_W-1:0] MEM_WRITE = 2'd3;

endpackage

`default_nettype wire

// File: rtl/smeu_stack_ram.sv
// Stack storage: one write port, two registered read ports.
// Depends on smeu_pkg for the data width.
`default_nettype none

module smeu_stack_ram
  import smeu_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF,
  parameter int AW    = $clog2(STACK_DEPTH_DEF)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr0,
  input  wire logic [AW-1:0]     raddr1,
  output logic      [DATA_W-1:0] rdata0,
  output logic      [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

// File: rtl/smeu_divider.sv
// Restoring divider, one quotient bit per cycle, for the DIV instruction.
// Depends on smeu_pkg for the data width.
`default_nettype none

module smeu_divider
  import smeu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   busy,
  output logic      [DATA_W-1:0] quotient
);

  localparam int CNTW = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [CNTW-1:0]   cnt;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;
  logic              fits;

  assign shifted  = {rem, quo[DATA_W-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign fits     = ~trial[DATA_W];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(DATA_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: rtl/stack_machine_execute_unit_core.sv
// Top level of the stack machine execute unit: sequencer, operand logic, registers.
// Depends on smeu_pkg, smeu_stack_ram and smeu_divider.
//
//   channel | handshake           | payload
//   in      | in_valid / in_ready | cmd, arg_kind, arg_value, mem_byte
//   out     | out_valid/out_ready | next_pc, mem_op, mem_value, top_value,
//           |                     | stack_depth, halted, div_zero
//   cfg     | cfg_valid/cfg_ready | cfg_data (program length)
//
// ST_IDLE accepts an instruction, then ST_EXEC read-modify-writes the stack RAM.
// SWP, and IFG/IFL without argument on a stack of under two entries, add ST_WR2:
// the second stack entry goes through the single RAM write port in that state.
// DIV with a divisor in range adds ST_DIV: 16 steps of the bit-serial divider.
// Reset clears control registers, not RAM; entries past the depth read as zero.
// A full output register holds the finishing instruction until the beat is taken.
`default_nettype none

module stack_machine_execute_unit_core
  import smeu_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [CMD_W-1:0]       cmd,
  input  wire logic [KIND_W-1:0]      arg_kind,
  input  wire logic [ARG_W-1:0]       arg_value,
  input  wire logic [7:0]             mem_byte,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [DATA_W-1:0]      next_pc,
  output logic      [MEMOP_W-1:0]     mem_op,
  output logic      [ARG_W-1:0]       mem_value,
  output logic      [DATA_W-1:0]      top_value,
  output logic      [DEPTH_OUT_W-1:0] stack_depth,
  output logic                        halted,
  output logic                        div_zero,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [DATA_W-1:0]      cfg_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_WR2  = 2'd3;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(STACK_DEPTH - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(STACK_DEPTH - 1) : AW'(p - 1'b1);
  endfunction

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [AW-1:0]      tp;
  logic [CW-1:0]      count;
  logic [DATA_W-1:0]  pc;
  logic [DATA_W-1:0]  ret;
  logic [DATA_W-1:0]  plen;

  logic [CMD_W-1:0]   i_cmd;
  logic [KIND_W-1:0]  i_kind;
  logic [ARG_W-1:0]   i_arg;
  logic [7:0]         i_byte;
  logic [AW-1:0]      w1_addr;
  logic [DATA_W-1:0]  w1_data;

  logic [DATA_W-1:0]  rd0;
  logic [DATA_W-1:0]  rd1;
  logic [AW-1:0]      tp1;
  logic               div_busy;
  logic [DATA_W-1:0]  div_quo;
  logic               div_start;

  logic               none;
  logic [ARG_W-1:0]   argv;
  logic [DATA_W-1:0]  a;
  logic [DATA_W-1:0]  b;
  logic [DATA_W-1:0]  x16;
  logic [ARG_W-1:0]   y32;
  logic [DATA_W-1:0]  y16;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]  r;
  logic               div_needed;
  logic               halt;
  logic [CW-1:0]      c1;
  logic [CW-1:0]      c2;

  logic [AW-1:0]      tp_n;
  logic [CW-1:0]      c_n;
  logic [DATA_W-1:0]  pc_n;
  logic [DATA_W-1:0]  ret_n;
  logic [MEMOP_W-1:0] mop_n;
  logic [ARG_W-1:0]   mval_n;
  logic [DATA_W-1:0]  top_n;
  logic               dz_n;
  logic               we0;
  logic [AW-1:0]      wa0;
  logic [DATA_W-1:0]  wd0;
  logic               need_w1;
  logic [DATA_W-1:0]  wd1;

  logic               out_free;
  logic               commit;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;

  assign tp1       = ptr_inc(tp);
  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = ~out_valid | out_ready;

  smeu_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (tp),
    .raddr1 (tp1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  smeu_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (x16),
    .divisor  (y16),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Operands: entries at or beyond the depth read as zero.
  always_comb begin
    none = (i_kind == KIND_NONE);
    argv = none ? '0 : i_arg;
    a    = (count != '0) ? rd0 : '0;
    b    = (count >= CW'(2)) ? rd1 : '0;
    x16  = none ? b : a;
    y32  = none ? {{(ARG_W-DATA_W){1'b0}}, a} : argv;
    y16  = y32[DATA_W-1:0];
    prod = x16 * y16;
    halt = (pc >= plen);
    c1   = (count == '0) ? CW'(1) : count;
    c2   = (count < CW'(2)) ? CW'(2) : count;
    div_needed = (i_cmd == OP_DIV) && (y32 != '0) && (y32[ARG_W-1:DATA_W] == '0);
    case (i_cmd)
      OP_ADD:  r = x16 + y16;
      OP_SUB:  r = x16 - y16;
      OP_MUL:  r = prod[DATA_W-1:0];
      OP_DIV:  r = (y32 == '0) ? '1 : ((y32[ARG_W-1:DATA_W] != '0) ? '0 : div_quo);
      OP_AND:  r = x16 & y16;
      OP_NOR:  r = ~(x16 | y16);
      default: r = '0;
    endcase
  end

  // Effect of the held instruction on stack, pc, return register and result fields.
  always_comb begin
    tp_n    = tp;
    c_n     = count;
    pc_n    = pc + 1'b1;
    ret_n   = ret;
    mop_n   = MEM_NONE;
    mval_n  = '0;
    top_n   = a;
    dz_n    = 1'b0;
    we0     = 1'b0;
    wa0     = tp;
    wd0     = a;
    need_w1 = 1'b0;
    wd1     = b;
    if (halt) begin
      pc_n = pc;
    end else begin
      case (i_cmd)
        OP_MOV: begin
          if (i_kind == KIND_ADDR) begin
            mop_n  = MEM_SET;
            mval_n = argv;
          end else if (none) begin
            mop_n  = MEM_MOVE;
            mval_n = {{(ARG_W-DATA_W){1'b0}}, a};
            we0    = 1'b1;
            c_n    = c1;
          end else begin
            mop_n  = MEM_MOVE;
            mval_n = argv;
          end
        end
        OP_PSH: begin
          tp_n  = ptr_dec(tp);
          wa0   = ptr_dec(tp);
          wd0   = none ? {{(DATA_W-8){1'b0}}, i_byte} : argv[DATA_W-1:0];
          top_n = wd0;
          we0   = 1'b1;
          c_n   = (count == CW'(STACK_DEPTH)) ? count : CW'(count + 1'b1);
        end
        OP_POP: begin
          mop_n = MEM_WRITE;
          if (none) begin
            mval_n = {{(ARG_W-DATA_W){1'b0}}, a};
            if (count != '0) begin
              tp_n  = tp1;
              c_n   = count - 1'b1;
              top_n = b;
            end
          end else begin
            mval_n = argv;
          end
        end
        OP_SWP: begin
          we0     = 1'b1;
          wd0     = b;
          need_w1 = 1'b1;
          wd1     = a;
          c_n     = c2;
          top_n   = b;
        end
        OP_REM: begin
          if (count != '0) begin
            tp_n  = tp1;
            c_n   = count - 1'b1;
            top_n = b;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_NOR: begin
          we0   = 1'b1;
          wd0   = r;
          top_n = r;
          dz_n  = (i_cmd == OP_DIV) && (y32 == '0);
          if (none) begin
            // drop the second entry: result lands one place down
            tp_n = tp1;
            wa0  = tp1;
            c_n  = c2 - 1'b1;
          end else begin
            c_n = c1;
          end
        end
        OP_NEG: begin
          we0   = 1'b1;
          wd0   = '0 - a;
          top_n = '0 - a;
          c_n   = c1;
        end
        OP_IFZ, OP_IFN: begin
          we0 = 1'b1;
          c_n = c1;
          if ((i_cmd == OP_IFZ) == (a != '0)) begin
            pc_n = pc + 2'd2;
          end
        end
        OP_IFG, OP_IFL: begin
          we0 = 1'b1;
          if (none) begin
            need_w1 = (count < CW'(2));
            c_n     = c2;
          end else begin
            c_n = c1;
          end
          if (i_cmd == OP_IFG) begin
            if ({{(ARG_W-DATA_W){1'b0}}, x16} <= y32) pc_n = pc + 2'd2;
          end else begin
            if ({{(ARG_W-DATA_W){1'b0}}, x16} >= y32) pc_n = pc + 2'd2;
          end
        end
        OP_JMP: begin
          pc_n = argv[DATA_W-1:0];
        end
        OP_JSR: begin
          ret_n = pc;
          pc_n  = argv[DATA_W-1:0];
        end
        OP_RET: begin
          pc_n = ret + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    div_start  = (state == ST_EXEC) && !halt && div_needed;
    commit     = out_free && (((state == ST_EXEC) && !div_start) ||
                              ((state == ST_DIV) && !div_busy));
    ram_we     = (commit && we0) || (state == ST_WR2);
    ram_waddr  = (state == ST_WR2) ? w1_addr : wa0;
    ram_wdata  = (state == ST_WR2) ? w1_data : wd0;
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (div_start) begin
          state_next = ST_DIV;
        end else if (commit) begin
          state_next = need_w1 ? ST_WR2 : ST_IDLE;
        end
      end
      ST_DIV:  if (commit) state_next = ST_IDLE;
      ST_WR2:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tp        <= '0;
      count     <= '0;
      pc        <= '0;
      ret       <= '0;
      plen      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        plen <= cfg_data;
      end
      if (commit) begin
        tp        <= tp_n;
        count     <= c_n;
        pc        <= pc_n;
        ret       <= ret_n;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      i_cmd  <= cmd;
      i_kind <= arg_kind;
      i_arg  <= arg_value;
      i_byte <= mem_byte;
    end
    if (commit) begin
      // hold the second stack entry for the following write cycle
      w1_addr     <= tp1;
      w1_data     <= wd1;
      next_pc     <= pc_n;
      mem_op      <= mop_n;
      mem_value   <= mval_n;
      top_value   <= (c_n != '0) ? top_n : '0;
      stack_depth <= DEPTH_OUT_W'(c_n);
      halted      <= halt;
      div_zero    <= dz_n;
    end
  end

endmodule

`default_nettype wire

// File: rtl/smeu_checker.sv
// Port-level checks on the result channel of the execute unit, bound to the top level.
// Depends on smeu_pkg and stack_machine_execute_unit_core.
`default_nettype none

module smeu_checker
  import smeu_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [DATA_W-1:0]  next_pc,
  input wire logic [MEMOP_W-1:0] mem_op,
  input wire logic [ARG_W-1:0]   mem_value,
  input wire logic [DATA_W-1:0]  top_value,
  input wire logic               halted,
  input wire logic               div_zero
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(top_value)
      && $stable(mem_value) && $stable(mem_op))
    else $error("result beat changed while stalled");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> mem_op == MEM_NONE && mem_value == '0 && !div_zero)
    else $error("halted beat carries a request or a flag");

  a_no_req_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && mem_op == MEM_NONE |-> mem_value == '0)
    else $error("value present without a memory request");

  a_div_zero_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> top_value == '1 && mem_op == MEM_NONE && !halted)
    else $error("division by zero without all-ones result");

endmodule

bind stack_machine_execute_unit_core smeu_checker u_smeu_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .next_pc   (next_pc),
  .mem_op    (mem_op),
  .mem_value (mem_value),
  .top_value (top_value),
  .halted    (halted),
  .div_zero  (div_zero)
);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the stack machine execute unit.
// Depends on smeu_pkg and stack_machine_execute_unit_core; predicts each result in-line.
`timescale 1ns / 100ps

module testbench;
  import smeu_pkg::*;

  localparam int STACK_SLOTS = 16;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [CMD_W-1:0]  OP_SPARE   = 5'd31;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [KIND_W-1:0] kind;
    logic [ARG_W-1:0]  arg;
    logic [7:0]        mbyte;
  } instr_t;

  typedef struct packed {
    logic [DATA_W-1:0]      next_pc;
    logic [MEMOP_W-1:0]     mem_op;
    logic [ARG_W-1:0]       mem_value;
    logic [DATA_W-1:0]      top;
    logic [DEPTH_OUT_W-1:0] depth;
    logic                   halted;
    logic                   div_zero;
  } result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CMD_W-1:0]       cmd = '0;
  logic [KIND_W-1:0]      arg_kind = '0;
  logic [ARG_W-1:0]       arg_value = '0;
  logic [7:0]             mem_byte = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [DATA_W-1:0]      next_pc;
  logic [MEMOP_W-1:0]     mem_op;
  logic [ARG_W-1:0]       mem_value;
  logic [DATA_W-1:0]      top_value;
  logic [DEPTH_OUT_W-1:0] stack_depth;
  logic                   halted;
  logic                   div_zero;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [DATA_W-1:0]      cfg_data = '0;

  // Machine state as the unit should hold it
  logic [STACK_SLOTS-1:0][15:0] stack_mem = '0;
  int                           stack_fill = 0;
  logic [15:0]                  pc_model = '0;
  logic [15:0]                  link_model = '0;
  logic [15:0]                  prog_len = '0;

  result_t pending_results[$];
  result_t want;

  int send_idle = 0;
  int recv_idle = 0;
  int items_left = 0;
  int halted_run = 0;
  int mismatches = 0;
  int n_results = 0;
  int n_halted = 0;
  int n_div_zero = 0;
  int n_full_stack = 0;
  int cfg_writes = 0;

  stack_machine_execute_unit_core #(
    .STACK_DEPTH(STACK_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .arg_kind(arg_kind),
    .arg_value(arg_value),
    .mem_byte(mem_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .next_pc(next_pc),
    .mem_op(mem_op),
    .mem_value(mem_value),
    .top_value(top_value),
    .stack_depth(stack_depth),
    .halted(halted),
    .div_zero(div_zero),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Missing operands are zeros slid in underneath the existing entries
  function automatic void fill_stack(int n);
    while (stack_fill < n && stack_fill < STACK_SLOTS) begin
      stack_mem[stack_fill] = '0;
      stack_fill++;
    end
  endfunction

  function automatic logic [15:0] pop_word();
    logic [15:0] v;
    v = '0;
    if (stack_fill > 0) begin
      v = stack_mem[0];
      for (int i = 0; i < stack_fill - 1; i++) stack_mem[i] = stack_mem[i+1];
      stack_fill--;
    end
    return v;
  endfunction

  function automatic result_t execute_instr(instr_t ins);
    result_t     r;
    logic [31:0] argv, x, y, acc;
    logic [15:0] pc, scrap;
    logic        no_arg;
    r = '0;
    no_arg = (ins.kind == KIND_NONE);
    argv = no_arg ? 32'd0 : ins.arg;
    pc = pc_model;
    x = '0;
    y = '0;
    acc = '0;
    if (pc >= prog_len) begin
      r.halted = 1'b1;
    end else begin
      case (ins.op)
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_NOR, OP_IFG, OP_IFL: begin
          if (no_arg) begin
            fill_stack(2);
            x = {16'd0, stack_mem[1]};
            y = {16'd0, stack_mem[0]};
          end else begin
            fill_stack(1);
            x = {16'd0, stack_mem[0]};
            y = argv;
          end
        end
        default: ;
      endcase
      case (ins.op)
        OP_MOV: begin
          if (ins.kind == KIND_ADDR) begin
            r.mem_op = MEM_SET;
            r.mem_value = argv;
          end else if (no_arg) begin
            fill_stack(1);
            r.mem_op = MEM_MOVE;
            r.mem_value = {16'd0, stack_mem[0]};
          end else begin
            r.mem_op = MEM_MOVE;
            r.mem_value = argv;
          end
        end
        OP_PSH: begin
          for (int i = STACK_SLOTS - 1; i > 0; i--) stack_mem[i] = stack_mem[i-1];
          stack_mem[0] = no_arg ? {8'd0, ins.mbyte} : argv[15:0];
          if (stack_fill < STACK_SLOTS) stack_fill++;
        end
        OP_POP: begin
          r.mem_op = MEM_WRITE;
          r.mem_value = no_arg ? {16'd0, pop_word()} : argv;
        end
        OP_SWP: begin
          fill_stack(2);
          scrap = stack_mem[0];
          stack_mem[0] = stack_mem[1];
          stack_mem[1] = scrap;
        end
        OP_REM: scrap = pop_word();
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_NOR: begin
          case (ins.op)
            OP_ADD: acc = x + y;
            OP_SUB: acc = x - y;
            OP_MUL: acc = x * y;
            OP_DIV: begin
              if (y == 0) begin
                acc = 32'h0000_FFFF;
                r.div_zero = 1'b1;
              end else begin
                acc = x / y;
              end
            end
            OP_AND: acc = x & y;
            default: acc = ~(x | y);
          endcase
          stack_mem[0] = acc[15:0];
          // two-operand form consumes the second entry
          if (no_arg && stack_fill >= 2) begin
            for (int i = 1; i < stack_fill - 1; i++) stack_mem[i] = stack_mem[i+1];
            stack_fill--;
          end
        end
        OP_NEG: begin
          fill_stack(1);
          stack_mem[0] = 16'd0 - stack_mem[0];
        end
        OP_IFZ: begin
          fill_stack(1);
          if (stack_mem[0] != 0) pc = pc + 16'd1;
        end
        OP_IFN: begin
          fill_stack(1);
          if (stack_mem[0] == 0) pc = pc + 16'd1;
        end
        OP_IFG: if (x <= y) pc = pc + 16'd1;
        OP_IFL: if (x >= y) pc = pc + 16'd1;
        OP_JMP: pc = argv[15:0] - 16'd1;
        OP_JSR: begin
          link_model = pc;
          pc = argv[15:0] - 16'd1;
        end
        OP_RET: pc = link_model;
        default: ;
      endcase
      pc_model = pc + 16'd1;
    end
    r.next_pc = pc_model;
    r.top = (stack_fill != 0) ? stack_mem[0] : 16'd0;
    r.depth = stack_fill[DEPTH_OUT_W-1:0];
    return r;
  endfunction

  // Where would the pc go, without disturbing the machine state
  function automatic logic [15:0] peek_next_pc(instr_t ins);
    logic [STACK_SLOTS-1:0][15:0] saved_mem;
    int                           saved_fill;
    logic [15:0]                  saved_pc, saved_link;
    result_t                      r;
    saved_mem = stack_mem;
    saved_fill = stack_fill;
    saved_pc = pc_model;
    saved_link = link_model;
    r = execute_instr(ins);
    stack_mem = saved_mem;
    stack_fill = saved_fill;
    pc_model = saved_pc;
    link_model = saved_link;
    return r.next_pc;
  endfunction

  function automatic instr_t make_instr(logic [CMD_W-1:0] op, logic [KIND_W-1:0] kind,
                                        logic [ARG_W-1:0] arg, logic [7:0] mbyte);
    instr_t ins;
    ins.op = op;
    ins.kind = kind;
    ins.arg = arg;
    ins.mbyte = mbyte;
    return ins;
  endfunction

  function automatic logic [ARG_W-1:0] rand_arg();
    case ($urandom_range(0, 6))
      0: return $urandom_range(0, 15);
      1: return $urandom_range(0, 65535);
      2: return 32'h0000_FFFF;
      3: return 32'h0001_0000 | $urandom_range(0, 1);
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] rand_kind();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 9) return KIND_NONE;
    if (r < 13) return KIND_ADDR;
    if (r < 19) return KIND_IMM;
    return KIND_SPARE;
  endfunction

  function automatic logic [CMD_W-1:0] rand_op(int unsigned top);
    return CMD_W'($urandom_range(0, top));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_target();
    int lim;
    if (prog_len == 16'h0000) lim = 0;
    else if (prog_len == 16'hFFFF) lim = 65534;
    else lim = int'(prog_len) - 1;
    return 16'($urandom_range(0, lim));
  endfunction

  // Usually keep some headroom past the current pc so the new program is not dead on arrival
  function automatic logic [15:0] pick_length();
    int want_len;
    case ($urandom_range(0, 7))
      0, 1, 2: want_len = 65535;
      3, 4:    want_len = pc_model + $urandom_range(1, 24);
      5, 6:    want_len = $urandom_range(pc_model + 1, 65535);
      default: want_len = ($urandom_range(0, 3) == 0) ? 0 : pc_model + 1 + $urandom_range(0, 400);
    endcase
    if (want_len > 65535) want_len = 65535;
    return want_len[15:0];
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing outstanding: next_pc 0x%0h", next_pc);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc", 32'(want.next_pc), 32'(next_pc));
        check_field("mem_op", 32'(want.mem_op), 32'(mem_op));
        check_field("mem_value", want.mem_value, mem_value);
        check_field("top_value", 32'(want.top), 32'(top_value));
        check_field("stack_depth", 32'(want.depth), 32'(stack_depth));
        check_field("halted", 32'(want.halted), 32'(halted));
        check_field("div_zero", 32'(want.div_zero), 32'(div_zero));
        n_results++;
        if (want.halted) n_halted++;
        if (want.div_zero) n_div_zero++;
        if (want.depth == STACK_SLOTS) n_full_stack++;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Append one predicted result behind those still outstanding
  task automatic queue_result(result_t res);
    pending_results = {pending_results, res};
  endtask

  // Enter and leave at a rising edge; valid stays high after the beat
  task automatic send_instr(instr_t ins);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= ins.op;
    arg_kind  <= ins.kind;
    arg_value <= ins.arg;
    mem_byte  <= ins.mbyte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queue_result(execute_instr(ins));
  endtask

  task automatic exec_op(logic [CMD_W-1:0] op, logic [KIND_W-1:0] kind,
                         logic [ARG_W-1:0] arg, logic [7:0] mbyte);
    send_instr(make_instr(op, kind, arg, mbyte));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_prog_len(logic [15:0] len);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    prog_len = len;
    cfg_writes++;
  endtask

  // Steer away from pc 0xFFFF (never executable) and mostly away from the program end
  task automatic issue(instr_t ins);
    logic [15:0] dest;
    if (pc_model >= prog_len) begin
      halted_run++;
      if (halted_run <= 4) send_instr(ins);
    end else begin
      dest = peek_next_pc(ins);
      if (dest == 16'hFFFF || (dest >= prog_len && $urandom_range(0, 29) != 0))
        ins = make_instr(OP_JMP, KIND_IMM, ($urandom & 32'hFFFF_0000) | pick_target(),
                         rand_byte());
      send_instr(ins);
      items_left--;
    end
    if ($urandom_range(0, 59) == 0) wait_drain();
  endtask

  task automatic test_halt_on_reset();
    send_idle = 0;
    recv_idle = 0;
    exec_op(OP_PSH, KIND_IMM, 32'd5, 8'h00);
    exec_op(OP_JMP, KIND_IMM, 32'd3, 8'h00);
    write_prog_len(16'd0);
    exec_op(OP_SPARE, KIND_SPARE, 32'hFFFF_FFFF, 8'hFF);
  endtask

  task automatic test_stack_words();
    write_prog_len(16'hFFFF);
    exec_op(OP_PSH, KIND_IMM, 32'hABCD_1234, 8'h00);
    exec_op(OP_PSH, KIND_NONE, 32'hFFFF_FFFF, 8'hFF);
    exec_op(OP_SWP, KIND_NONE, 32'd0, 8'h00);
    exec_op(OP_POP, KIND_NONE, 32'd0, 8'h00);
    exec_op(OP_POP, KIND_ADDR, 32'hFFFF_FFFF, 8'h00);
    exec_op(OP_REM, KIND_NONE, 32'd0, 8'h00);
    exec_op(OP_REM, KIND_NONE, 32'd0, 8'h00);
    exec_op(OP_POP, KIND_NONE, 32'd0, 8'h00);
    exec_op(OP_MOV, KIND_NONE, 32'd0, 8'h00);
    exec_op(OP_MOV, KIND_ADDR, 32'h8000_0001, 8'h00);
    exec_op(OP_MOV, KIND_SPARE, 32'h0000_00FF, 8'h00);
  endtask

  task automatic test_arithmetic();
    exec_op(OP_PSH, KIND_IMM, 32'd7, 8'h00);
    exec_op(OP_DIV, KIND_IMM, 32'd0, 8'h00);
    exec_op(OP_DIV, KIND_IMM, 32'h0001_0000, 8'h00);
    exec_op(OP_SUB, KIND_IMM, 32'd1, 8'h00);
    exec_op(OP_NEG, KIND_NONE, 32'd0, 8'h00);
    exec_op(OP_PSH, KIND_IMM, 32'h0000_FFFF, 8'h00);
    exec_op(OP_MUL, KIND_NONE, 32'd0, 8'h00);
    exec_op(OP_AND, KIND_IMM, 32'h0000_0F0F, 8'h00);
    exec_op(OP_NOR, KIND_NONE, 32'd0, 8'h00);
    exec_op(OP_ADD, KIND_IMM, 32'hFFFF_FFFF, 8'h00);
  endtask

  task automatic test_control_flow();
    exec_op(OP_PSH, KIND_IMM, 32'd0, 8'h00);
    exec_op(OP_IFZ, KIND_NONE, 32'd0, 8'h00);
    exec_op(OP_IFN, KIND_NONE, 32'd0, 8'h00);
    exec_op(OP_IFG, KIND_IMM, 32'h0001_0000, 8'h00);
    exec_op(OP_IFL, KIND_NONE, 32'd0, 8'h00);
    exec_op(OP_JSR, KIND_IMM, 32'd200, 8'h00);
    exec_op(OP_RET, KIND_NONE, 32'd0, 8'h00);
    exec_op(OP_JMP, KIND_ADDR, 32'd0, 8'h00);
    exec_op(OP_SPARE, KIND_NONE, 32'd0, 8'h00);
    // park at the last executable pc, then skip across the wrap to 0
    exec_op(OP_PSH, KIND_IMM, 32'd9, 8'h00);
    exec_op(OP_JMP, KIND_IMM, 32'hFFFF_FFFE, 8'h00);
    exec_op(OP_IFZ, KIND_NONE, 32'd0, 8'h00);
  endtask

  task automatic test_random_programs(int budget, int s_pct, int r_pct);
    int               stop_at;
    logic [CMD_W-1:0] cond_op;
    send_idle = s_pct;
    recv_idle = r_pct;
    items_left = budget;
    while (items_left > 0) begin
      write_prog_len(pick_length());
      halted_run = 0;
      stop_at = items_left - $urandom_range(30, 120);
      while (items_left > 0 && items_left > stop_at && halted_run < 4) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            repeat ($urandom_range(1, 3))
              issue(make_instr(OP_PSH, $urandom_range(0, 1) ? KIND_IMM : KIND_NONE,
                               rand_arg(), rand_byte()));
            issue(make_instr(rand_op(OP_RET), rand_kind(), rand_arg(), rand_byte()));
          end
          4: begin
            case ($urandom_range(0, 3))
              0: cond_op = OP_IFZ;
              1: cond_op = OP_IFN;
              2: cond_op = OP_IFG;
              default: cond_op = OP_IFL;
            endcase
            repeat ($urandom_range(1, 2))
              issue(make_instr(OP_PSH, KIND_IMM, rand_arg(), rand_byte()));
            issue(make_instr(cond_op, rand_kind(), rand_arg(), rand_byte()));
          end
          5: begin
            issue(make_instr(OP_JSR, $urandom_range(0, 1) ? KIND_IMM : KIND_ADDR,
                             ($urandom & 32'hFFFF_0000) | pick_target(), rand_byte()));
            repeat ($urandom_range(1, 3))
              issue(make_instr(rand_op(OP_NOR), rand_kind(), rand_arg(), rand_byte()));
            issue(make_instr(OP_RET, rand_kind(), rand_arg(), rand_byte()));
          end
          6: begin
            // overrun the stack so the bottom entry drops off, or else issue a DIV
            if ($urandom_range(0, 2) == 0)
              repeat ($urandom_range(17, 20))
                issue(make_instr(OP_PSH, rand_kind(), rand_arg(), rand_byte()));
            else
              issue(make_instr(OP_DIV, rand_kind(), rand_arg(), rand_byte()));
          end
          7: begin
            repeat ($urandom_range(1, 4))
              issue(make_instr($urandom_range(0, 1) ? OP_POP : OP_REM, rand_kind(),
                               rand_arg(), rand_byte()));
          end
          default: begin
            issue(make_instr(rand_op(OP_SPARE), KIND_W'($urandom_range(0, 3)), $urandom,
                             rand_byte()));
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_halt_on_reset();
    test_stack_words();
    test_arithmetic();
    test_control_flow();
    test_random_programs(450, 29, 66);
    test_random_programs(450, 66, 29);
    test_random_programs(450, 0, 0);
    wait_drain();
    repeat (40) @(posedge clk);
    $display("Run covered %0d instructions: %0d halted, %0d divisions by zero, %0d on a full stack",
             n_results, n_halted, n_div_zero, n_full_stack);
    $display("Program length rewritten %0d times; %0d field mismatches", cfg_writes, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[stack_machine_execute_unit_core] OK");
    end else begin
      $display("[stack_machine_execute_unit_core] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("[stack_machine_execute_unit_core] ERROR");
    $finish;
  end

endmodule
